/* rtl/tsnm_pkg.sv */
// ----------------------------------------------------------------------------
// tsnm_pkg: shared types and constants
// Sizes, command and result structs, codes and engine states for the
// timestamp nearest match buffer.
// ----------------------------------------------------------------------------
package tsnm_pkg;

	localparam int ENTRIES     = 16;
	localparam int HANDLE_BITS = 16;
	localparam int ADDR_W      = $clog2(ENTRIES);
	localparam int CNT_W       = $clog2(ENTRIES + 1);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_QUEUE_LIMIT = 1'b0,
		CFG_MAX_DIFF    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FAR   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_PUSH       = 2'd0,
		OP_POP_OLDEST = 2'd1,
		OP_POP_NEAR   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ENG_IDLE  = 2'd0,
		ENG_SCAN  = 2'd1,
		ENG_DRAIN = 2'd2,
		ENG_FIN   = 2'd3
	} eng_state_t;

	typedef struct packed {
		logic        command;
		logic        stream;
		logic [63:0] stamp;
		logic [15:0] handle;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] out_handle;
		logic [63:0] out_stamp;
		logic [4:0]  pair_count;
	} out_item_t;

	typedef struct packed {
		op_t                    op;
		logic                   stream;
		logic [63:0]            stamp;
		logic [HANDLE_BITS-1:0] handle;
	} cmd_t;

endpackage

/* rtl/tsnm_cmd_queue.sv */
// ----------------------------------------------------------------------------
// tsnm_cmd_queue: input front end
// Accepts input transactions, classifies each into push, pop of the oldest
// entry or pop of the nearest entry, and queues it for the engine.
// ----------------------------------------------------------------------------
module tsnm_cmd_queue
	import tsnm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     cmd_take
);

	cmd_t              buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	cmd_t              cls;
	logic              wr;
	logic              rd;

	always_comb begin
		cls.stream = item.stream;
		cls.stamp  = item.stamp;
		cls.handle = HANDLE_BITS'(item.handle);
		if (!item.command) begin
			cls.op = OP_PUSH;
		end else if (item.stamp == 64'd0) begin
			cls.op = OP_POP_OLDEST;
		end else begin
			cls.op = OP_POP_NEAR;
		end
	end

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = buf_q[rd_ptr_q];
	assign wr        = push && !full;
	assign rd        = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(wr) - QCNT_W'(rd);
		end
	end

endmodule

/* rtl/tsnm_engine.sv */
// ----------------------------------------------------------------------------
// tsnm_engine: table engine
// Holds both tables, scans the selected table one slot a cycle for the
// nearest or oldest entry, then commits the push or pop and emits a result.
// ----------------------------------------------------------------------------
module tsnm_engine
	import tsnm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  cmd_valid,
	input  cmd_t                  cmd,
	output logic                  cmd_take,
	input  logic                  res_full,
	output logic                  res_push,
	output out_item_t             res
);

	function automatic logic [63:0] abs_diff(input logic [63:0] a, input logic [63:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [CNT_W-1:0] eff_limit(input logic [4:0] q);
		if (q == 5'd0) begin
			return CNT_W'(1);
		end else if (q > ENTRIES) begin
			return CNT_W'(ENTRIES);
		end else begin
			return CNT_W'(q);
		end
	endfunction

	eng_state_t state_q;
	eng_state_t state_d;
	logic       scan_rd;

	logic [4:0]  queue_limit_q;
	logic [31:0] max_diff_q;

	logic [63:0]            stamp_mem  [2*ENTRIES];
	logic [HANDLE_BITS-1:0] handle_mem [2*ENTRIES];
	logic [ENTRIES-1:0]     valid_q    [2];
	logic [CNT_W-1:0]       occ_q      [2];

	cmd_t              cur_q;
	logic [ADDR_W-1:0] idx_q;

	logic                   rd_vld_s1;
	logic                   rd_valid_s1;
	logic [ADDR_W-1:0]      rd_idx_s1;
	logic [63:0]            rd_stamp_s1;
	logic [HANDLE_BITS-1:0] rd_handle_s1;

	logic                   best_found_q;
	logic [63:0]            best_dist_q;
	logic [63:0]            best_stamp_q;
	logic [HANDLE_BITS-1:0] best_handle_q;
	logic [ADDR_W-1:0]      best_slot_q;
	logic                   eq_found_q;
	logic [ADDR_W-1:0]      eq_slot_q;
	logic                   free_found_q;
	logic [ADDR_W-1:0]      free_slot_q;

	logic [63:0]        cand_dist;
	logic               better;
	logic [CNT_W-1:0]   sel_occ;
	logic [CNT_W-1:0]   oth_occ;
	logic [CNT_W-1:0]   new_occ;
	logic [ENTRIES-1:0] sel_valid_d;
	logic               is_push;
	logic               too_far;
	logic               pop_ok;
	logic               evict;
	logic               eq_use;
	logic               wr_ok;
	logic               add_new;
	logic [ADDR_W-1:0]  slot;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ENG_IDLE: begin
				if (cmd_valid) begin
					state_d = ENG_SCAN;
				end
			end
			ENG_SCAN: begin
				if (idx_q == ADDR_W'(ENTRIES - 1)) begin
					state_d = ENG_DRAIN;
				end
			end
			ENG_DRAIN: state_d = ENG_FIN;
			ENG_FIN: begin
				if (!res_full) begin
					state_d = ENG_IDLE;
				end
			end
			default: state_d = ENG_IDLE;
		endcase
	end

	always_comb begin
		cmd_take = (state_q == ENG_IDLE) && cmd_valid;
		scan_rd  = (state_q == ENG_SCAN);
		res_push = (state_q == ENG_FIN) && !res_full;
	end

	always_comb begin
		cand_dist = (cur_q.op == OP_POP_NEAR) ? abs_diff(rd_stamp_s1, cur_q.stamp) :
			rd_stamp_s1;
		better    = !best_found_q || (cand_dist < best_dist_q) ||
			((cand_dist == best_dist_q) && (rd_stamp_s1 < best_stamp_q));
	end

	always_comb begin
		sel_occ = occ_q[cur_q.stream];
		oth_occ = occ_q[!cur_q.stream];
		is_push = (cur_q.op == OP_PUSH);
		too_far = (cur_q.op == OP_POP_NEAR) && cur_q.stream &&
			(best_dist_q > 64'(max_diff_q));
		pop_ok  = !is_push && best_found_q && !too_far;
		evict   = is_push && best_found_q && (sel_occ >= eff_limit(queue_limit_q));
		eq_use  = eq_found_q && !(evict && (eq_slot_q == best_slot_q));
		if (eq_use) begin
			slot = eq_slot_q;
		end else if (evict && (!free_found_q || (best_slot_q < free_slot_q))) begin
			slot = best_slot_q;
		end else begin
			slot = free_slot_q;
		end
		wr_ok   = is_push && (eq_use || evict || free_found_q);
		add_new = wr_ok && !eq_use;
		if (pop_ok) begin
			new_occ = sel_occ - 1'b1;
		end else if (is_push) begin
			new_occ = sel_occ - CNT_W'(evict) + CNT_W'(add_new);
		end else begin
			new_occ = sel_occ;
		end

		sel_valid_d = valid_q[cur_q.stream];
		if (pop_ok || evict) begin
			sel_valid_d[best_slot_q] = 1'b0;
		end
		if (wr_ok) begin
			sel_valid_d[slot] = 1'b1;
		end

		res.out_handle = '0;
		res.out_stamp  = '0;
		if (is_push) begin
			res.status = ST_OK;
		end else if (!best_found_q) begin
			res.status = ST_EMPTY;
		end else if (too_far) begin
			res.status = ST_FAR;
		end else begin
			res.status     = ST_OK;
			res.out_handle = 16'(best_handle_q);
			res.out_stamp  = best_stamp_q;
		end
		res.pair_count = 5'((new_occ < oth_occ) ? new_occ : oth_occ);
	end

	always_ff @(posedge clk) begin
		if (scan_rd) begin
			rd_stamp_s1  <= stamp_mem[{cur_q.stream, idx_q}];
			rd_handle_s1 <= handle_mem[{cur_q.stream, idx_q}];
		end
		if (res_push && wr_ok) begin
			stamp_mem[{cur_q.stream, slot}]  <= cur_q.stamp;
			handle_mem[{cur_q.stream, slot}] <= cur_q.handle;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cur_q <= cmd;
		end
		if (scan_rd) begin
			rd_idx_s1   <= idx_q;
			rd_valid_s1 <= valid_q[cur_q.stream][idx_q];
		end
		if (rd_vld_s1 && rd_valid_s1 && better) begin
			best_dist_q   <= cand_dist;
			best_stamp_q  <= rd_stamp_s1;
			best_handle_q <= rd_handle_s1;
			best_slot_q   <= rd_idx_s1;
		end
		if (rd_vld_s1 && rd_valid_s1 && !eq_found_q && (rd_stamp_s1 == cur_q.stamp)) begin
			eq_slot_q <= rd_idx_s1;
		end
		if (rd_vld_s1 && !rd_valid_s1 && !free_found_q) begin
			free_slot_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ENG_IDLE;
			queue_limit_q <= 5'd16;
			max_diff_q    <= 32'd20000000;
			valid_q[0]    <= '0;
			valid_q[1]    <= '0;
			occ_q[0]      <= '0;
			occ_q[1]      <= '0;
			idx_q         <= '0;
			rd_vld_s1     <= 1'b0;
			best_found_q  <= 1'b0;
			eq_found_q    <= 1'b0;
			free_found_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_rd;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_QUEUE_LIMIT: queue_limit_q <= cfg_data[4:0];
					CFG_MAX_DIFF:    max_diff_q    <= cfg_data;
					default:         ;
				endcase
			end
			if (cmd_take) begin
				idx_q        <= '0;
				best_found_q <= 1'b0;
				eq_found_q   <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (scan_rd) begin
					idx_q <= idx_q + 1'b1;
				end
				if (rd_vld_s1 && rd_valid_s1) begin
					best_found_q <= 1'b1;
					if (!is_push) begin
						eq_found_q <= eq_found_q;
					end else if (rd_stamp_s1 == cur_q.stamp) begin
						eq_found_q <= 1'b1;
					end
				end
				if (rd_vld_s1 && !rd_valid_s1) begin
					free_found_q <= 1'b1;
				end
			end
			if (res_push) begin
				occ_q[cur_q.stream]   <= new_occ;
				valid_q[cur_q.stream] <= sel_valid_d;
			end
		end
	end

endmodule

/* rtl/tsnm_res_queue.sv */
// ----------------------------------------------------------------------------
// tsnm_res_queue: result queue
// Holds finished results until the consumer pops them, so the engine can
// start the next command while a result waits.
// ----------------------------------------------------------------------------
module tsnm_res_queue
	import tsnm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_push,
	input  out_item_t res,
	output logic      res_full,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	out_item_t         buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              wr;
	logic              rd;

	assign res_full = (cnt_q == QCNT_W'(QDEPTH));
	assign empty    = (cnt_q == '0);
	assign result   = buf_q[rd_ptr_q];
	assign wr       = res_push && !res_full;
	assign rd       = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(wr) - QCNT_W'(rd);
		end
	end

endmodule

/* rtl/timestamp_nearest_match_buffer.sv */
// ----------------------------------------------------------------------------
// timestamp_nearest_match_buffer: image and depth nearest timestamp matching
// The engine scans one table slot per cycle and takes a new command only
// after its last result is pushed; the input queue holds two meanwhile.
// Reset: both tables empty, limits at reset values, no clearing pass.
// ----------------------------------------------------------------------------
module timestamp_nearest_match_buffer
	import tsnm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  in_item_t              item,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic      cmd_valid;
	cmd_t      cmd;
	logic      cmd_take;
	logic      res_full;
	logic      res_push;
	out_item_t res;

	tsnm_cmd_queue u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	tsnm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	tsnm_res_queue u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full result queue");

	a_fail_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.status != ST_OK) |-> (res.out_handle == '0 && res.out_stamp == '0))
		else $error("failed pop carries a payload");

	a_take_one_per_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> !cmd_take)
		else $error("engine took two commands back to back");

endmodule
